### sv/five_ary_max_heap_queue_core_defines.svh
// Assertion macros for the five-ary max heap queue core.
`ifndef FIVE_ARY_MAX_HEAP_QUEUE_CORE_DEFINES_SVH
`define FIVE_ARY_MAX_HEAP_QUEUE_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define FHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the following cycle.
`define FHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### sv/fhq_pkg.sv
// Package with shared types and constants of the heap queue core.
package fhq_pkg;
  localparam int Capacity = 1024;
  localparam int Arity    = 5;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  // Reciprocal of the arity for parent and leaf index math.
  localparam int DivShift = 20;
  localparam int DivRecip = ((1 << DivShift) + Arity - 1) / Arity;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELMAX = 3'd1;
  localparam logic [2:0] CMD_DELMIN = 3'd2;
  localparam logic [2:0] CMD_FNDMAX = 3'd3;
  localparam logic [2:0] CMD_FNDMIN = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request to the storage unit.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [31:0]      wdata;
    logic [AddrW-1:0] raddr;
  } fhq_mem_req_t;

  // Signed less-than.
  function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Divide a count-wide value by the arity with a reciprocal multiply.
  function automatic logic [CntW-1:0] div_arity(input logic [CntW-1:0] x);
    logic [CntW+DivShift-1:0] prod;
    prod = (CntW+DivShift)'(x) * (CntW+DivShift)'(DivRecip);
    return prod[CntW+DivShift-1:DivShift];
  endfunction
endpackage

### sv/five_ary_max_heap_queue_core.sv
// Top level: 5-ary max heap priority queue with a sequencer over one RAM with a write port and a read port.
// Errors and unused codes go from dispatch straight to the result; find max
// reads the root; insert climbs a level per parent read and compare; delete
// max per level reads each child and takes its data, then swaps with the best;
// find/delete min scan the leaves one per cycle.
// One item at a time; the next is accepted in the cycle after the result is taken.
// Reset (rst_n low, synchronous) empties the heap; store contents stay unknown.
`include "five_ary_max_heap_queue_core_defines.svh"
module five_ary_max_heap_queue_core
  import fhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] command, [34:3] value, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] result_value, [33:32] status,
                                  // [44:34] entry_count, zero fill
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DISP  = 12'b000000000010,
    S_UPRD  = 12'b000000000100, // read parent
    S_UPCMP = 12'b000000001000, // compare with parent
    S_DNRD  = 12'b000000010000, // issue child read
    S_DNCMP = 12'b000000100000, // take child data
    S_DNSW  = 12'b000001000000, // swap with best child
    S_MNRD  = 12'b000010000000, // root read or leaf scan
    S_MNEND = 12'b000100000000,
    S_LSTRD = 12'b001000000000, // read last entry
    S_LSTWR = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       cmd_r;
  logic [31:0]      cur_r;         // value being sifted
  logic [AddrW-1:0] pos_r;         // position of cur_r
  logic [AddrW-1:0] par_r;
  logic [CntW-1:0]  cnt_r;
  logic [AddrW-1:0] ptr_r;         // scan or child pointer
  logic [2:0]       kid_r;
  logic [AddrW-1:0] best_r;
  logic [31:0]      bval_r;
  logic             pend_r;        // a read is in flight for ptr of previous cycle
  logic [AddrW-1:0] pidx_r;
  logic [31:0]      res_r;
  logic [1:0]       st_r;
  fhq_mem_req_t     req;
  logic [31:0]      rdata;
  logic [CntW-1:0]  first_w;
  logic [CntW+2:0]  first_full;

  fhq_store u_store (.clk(clk), .req(req), .rdata(rdata));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, cnt_r, st_r, res_r};
  assign first_full = (CntW+3)'(pos_r) * (CntW+3)'(Arity) + (CntW+3)'(1);
  assign first_w    = (first_full > (CntW+3)'(Capacity)) ? CntW'(Capacity)
                                                         : first_full[CntW-1:0];

  always_comb begin
    req = '0;
    unique case (state_r)
      S_UPRD:  req.raddr = par_r;
      // first child comes straight from the position, later ones from ptr_r
      S_DNRD:  req.raddr = (kid_r == 3'd0) ? first_w[AddrW-1:0] : ptr_r;
      S_MNRD:  req.raddr = ptr_r;
      S_LSTRD: req.raddr = AddrW'(cnt_r);
      S_UPCMP: begin
        // at the root nothing is left to compare: place the value
        if (pos_r != '0 && key_less(rdata, cur_r)) begin
          req.we = 1'b1; req.waddr = pos_r; req.wdata = rdata;
        end else begin
          req.we = 1'b1; req.waddr = pos_r; req.wdata = cur_r;
        end
      end
      S_DNSW: begin
        req.we = 1'b1; req.waddr = pos_r;
        req.wdata = key_less(cur_r, bval_r) ? bval_r : cur_r;
      end
      default: req = '0;
    endcase
  end

  // Sequencer. Reads of the one port are registered, so each read is
  // issued in one state and used in the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tdata[2:0];
            cur_r   <= in_tdata[34:3];
            res_r   <= '0;
            st_r    <= ST_OK;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd_r) inside
            CMD_INSERT: begin
              if (cnt_r == CntW'(Capacity)) begin
                st_r    <= ST_FULL;
                state_r <= S_OUT;
              end else begin
                pos_r <= AddrW'(cnt_r);
                par_r <= AddrW'(div_arity(cnt_r - CntW'(1)));
                cnt_r <= cnt_r + CntW'(1);
                state_r <= (cnt_r == '0) ? S_UPCMP : S_UPRD;
              end
            end
            CMD_DELMAX, CMD_FNDMAX, CMD_DELMIN, CMD_FNDMIN: begin
              if (cnt_r == '0) begin
                st_r    <= ST_EMPTY;
                state_r <= S_OUT;
              end else if (cmd_r == CMD_DELMAX || cmd_r == CMD_FNDMAX) begin
                ptr_r   <= '0;
                pend_r  <= 1'b0;
                state_r <= S_MNRD;
                best_r  <= '0;
                kid_r   <= 3'd0;
              end else begin
                ptr_r  <= (cnt_r < CntW'(2)) ? '0
                          : AddrW'(div_arity(cnt_r - CntW'(2)) + CntW'(1));
                best_r <= (cnt_r < CntW'(2)) ? '0
                          : AddrW'(div_arity(cnt_r - CntW'(2)) + CntW'(1));
                pend_r <= 1'b0;
                kid_r  <= 3'd1;
                state_r <= S_MNRD;
              end
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_MNRD: begin
          // kid_r 0: single read of the root; 1: leaf scan
          pend_r <= 1'b1;
          pidx_r <= ptr_r;
          if (pend_r) begin
            if (pidx_r == best_r || key_less(rdata, bval_r)) begin
              bval_r <= rdata;
              best_r <= pidx_r;
            end
          end
          if (kid_r == 3'd0 || CntW'(ptr_r) + CntW'(1) >= cnt_r) begin
            state_r <= S_MNEND;
          end else begin
            ptr_r <= ptr_r + AddrW'(1);
          end
        end
        S_MNEND: begin
          if (pidx_r == best_r || key_less(rdata, bval_r)) begin
            bval_r <= rdata; best_r <= pidx_r;
            res_r  <= rdata; pos_r <= pidx_r;
          end else begin
            res_r  <= bval_r; pos_r <= best_r;
          end
          pend_r <= 1'b0;
          if (cmd_r == CMD_DELMAX || cmd_r == CMD_DELMIN) begin
            cnt_r   <= cnt_r - CntW'(1);
            state_r <= S_LSTRD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_LSTRD: state_r <= S_LSTWR;
        S_LSTWR: begin
          cur_r <= rdata;
          if (CntW'(pos_r) >= cnt_r) begin
            state_r <= S_OUT;
          end else if (cmd_r == CMD_DELMAX) begin
            state_r <= S_DNRD; kid_r <= 3'd0;
          end else if (pos_r == '0) begin
            state_r <= S_UPCMP;
          end else begin
            par_r <= AddrW'(div_arity(CntW'(pos_r) - CntW'(1)));
            state_r <= S_UPRD;
          end
        end
        S_UPRD: state_r <= S_UPCMP;
        S_UPCMP: begin
          if (pos_r != '0 && key_less(rdata, cur_r)) begin
            pos_r <= par_r;
            if (par_r == '0) begin
              state_r <= S_UPCMP;
            end else begin
              par_r <= AddrW'(div_arity(CntW'(par_r) - CntW'(1)));
              state_r <= S_UPRD;
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DNRD: begin
          // first child read, or next child
          if (kid_r == 3'd0) begin
            if (first_w >= cnt_r) begin
              state_r <= S_DNSW; bval_r <= cur_r;
            end else begin
              ptr_r <= first_w[AddrW-1:0];
              state_r <= S_DNCMP;
            end
          end else begin
            state_r <= S_DNCMP;
          end
        end
        S_DNCMP: begin
          if (kid_r == 3'd0 || key_less(bval_r, rdata)) begin
            bval_r <= rdata; best_r <= ptr_r;
          end
          if (kid_r == 3'(Arity - 1) || CntW'(ptr_r) + CntW'(1) >= cnt_r) begin
            state_r <= S_DNSW;
          end else begin
            kid_r <= kid_r + 3'd1;
            ptr_r <= ptr_r + AddrW'(1);
            state_r <= S_DNRD;
          end
        end
        S_DNSW: begin
          if (key_less(cur_r, bval_r)) begin
            pos_r <= best_r; kid_r <= 3'd0; state_r <= S_DNRD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FHQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CntW'(Capacity), "count above capacity")
  `FHQ_ASSERT_IMP(a_rdy_out, out_tvalid, !in_tready, "ready while result waits")
  `FHQ_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata) && out_tvalid,
    "result changed while stalled")
  `FHQ_ASSERT_IMP(a_full_zero, out_tvalid && st_r != ST_OK, res_r == '0,
    "error result not zero")
endmodule

### sv/fhq_store.sv
// Heap storage: one write port and one registered read port.
module fhq_store
  import fhq_pkg::*;
(
  input  logic         clk,
  input  fhq_mem_req_t req,
  output logic [31:0]  rdata
);
  logic [31:0] mem [Capacity];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
